FILE: rtl/u8u16_pkg.sv
// Shared types and constants for the UTF-8 to UTF-16 transcoder.
// Used by the front decoder, the job queue and the back emitter.
`timescale 1ns / 1ps

package u8u16_pkg;

    localparam int BYTE_W  = 8;
    localparam int UNIT_W  = 16;
    localparam int PEND_W  = 3;
    localparam int POINT_W = 31;

    localparam logic [POINT_W-1:0] SUPP_BASE = POINT_W'(32'h0001_0000);
    localparam logic [UNIT_W-1:0]  HI_SURR   = 16'hD800;
    localparam logic [5:0]         LO_SURR   = 6'b110111;  // 0xDC00 >> 10

    // Up to two code units produced by one input byte.
    typedef struct packed {
        logic              two;
        logic [UNIT_W-1:0] unit0;
        logic              bad0;
        logic [UNIT_W-1:0] unit1;
        logic              bad1;
    } job_t;

endpackage

FILE: rtl/utf8_to_utf16_transcoder_top.sv
// UTF-8 to UTF-16 transcoder, top level.
// Instantiates u8u16_front, u8u16_fifo and u8u16_back; depends on u8u16_pkg.
//
// Usage:
//   Input stream: one byte per word on s_tdata; s_tlast marks end of stream,
//   which flushes an unfinished sequence as its lead byte flagged bad (byte
//   value ignored on that word).
//   Output stream: one UTF-16 code unit per word on m_tdata; m_tuser flags a
//   raw byte from an illegal sequence; m_tlast marks the last word caused by
//   one input word. An input word yields zero, one or two output words.
//   A byte's job is registered in the job queue, then in the output
//   register. Throughput: one byte per cycle in while the queue has room.
//   Out: one word per cycle, so two-unit words (surrogate pairs, broken
//   sequences) take longer; the FIFO_DEPTH-entry job queue absorbs it.
//   When the receiver stalls, the output register holds its word and the
//   queue fills; s_tready drops only when the queue is full.
//   Reset (aresetn low, synchronous) closes any open sequence, empties the
//   queue and drops m_tvalid.
`timescale 1ns / 1ps

module utf8_to_utf16_transcoder_top
    import u8u16_pkg::*;
#(
    parameter int FIFO_DEPTH = 4
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [BYTE_W-1:0] s_tdata,   // [7:0] byte_value
    input  logic              s_tlast,   // end_of_data
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [UNIT_W-1:0] m_tdata,   // [15:0] code_unit
    output logic              m_tuser,   // [0] bad_sequence
    output logic              m_tlast    // last_of_run
);

    logic in_fire;
    logic job_valid;
    job_t job;
    logic full;
    logic empty;
    logic pop;
    job_t head;

    assign s_tready = !full;
    assign in_fire  = s_tvalid && !full;

    u8u16_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_fire   (in_fire),
        .in_byte   (s_tdata),
        .in_end    (s_tlast),
        .job_valid (job_valid),
        .job       (job)
    );

    u8u16_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (job_valid),
        .push_job (job),
        .full     (full),
        .pop      (pop),
        .empty    (empty),
        .head     (head)
    );

    u8u16_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .empty    (empty),
        .head     (head),
        .pop      (pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule

FILE: rtl/u8u16_front.sv
// Front end: takes bytes, tracks the open UTF-8 sequence and builds output jobs.
// Depends on u8u16_pkg.
`timescale 1ns / 1ps

module u8u16_front
    import u8u16_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              in_fire,
    input  logic [BYTE_W-1:0] in_byte,
    input  logic              in_end,
    output logic              job_valid,
    output job_t              job
);

    logic [PEND_W-1:0]  pend_reg, pend_next;
    logic [POINT_W-1:0] point_reg, point_next;
    logic [BYTE_W-1:0]  lead_reg, lead_next;

    logic               is_cont;
    logic               f_emit;
    logic               f_bad;
    logic [PEND_W-1:0]  f_pend;
    logic [POINT_W-1:0] f_point;
    logic [POINT_W-1:0] grown;
    logic [POINT_W-1:0] offs;
    logic [UNIT_W-1:0]  hi_unit;
    logic [UNIT_W-1:0]  lo_unit;

    assign is_cont = (in_byte[7:6] == 2'b10);

    // Classification of a byte taken with no sequence open.
    always_comb begin
        f_emit  = 1'b0;
        f_bad   = 1'b0;
        f_pend  = '0;
        f_point = '0;
        if (!in_byte[7]) begin
            f_emit = 1'b1;
        end else if (is_cont || in_byte[7:1] == 7'b1111111) begin
            f_emit = 1'b1;
            f_bad  = 1'b1;
        end else if (in_byte[7:5] == 3'b110) begin
            f_pend  = PEND_W'(1);
            f_point = POINT_W'(in_byte[4:0]);
        end else if (in_byte[7:4] == 4'b1110) begin
            f_pend  = PEND_W'(2);
            f_point = POINT_W'(in_byte[3:0]);
        end else if (in_byte[7:3] == 5'b11110) begin
            f_pend  = PEND_W'(3);
            f_point = POINT_W'(in_byte[2:0]);
        end else if (in_byte[7:2] == 6'b111110) begin
            f_pend  = PEND_W'(4);
            f_point = POINT_W'(in_byte[1:0]);
        end else begin
            f_pend  = PEND_W'(5);
            f_point = POINT_W'(in_byte[0]);
        end
    end

    assign grown   = {point_reg[POINT_W-7:0], in_byte[5:0]};
    assign offs    = grown - SUPP_BASE;
    assign hi_unit = HI_SURR + offs[25:10];
    assign lo_unit = {LO_SURR, offs[9:0]};

    always_comb begin
        pend_next  = pend_reg;
        point_next = point_reg;
        lead_next  = lead_reg;
        job_valid  = 1'b0;
        job        = '0;
        if (in_fire) begin
            if (in_end) begin
                if (pend_reg != '0) begin
                    job_valid = 1'b1;
                    job.unit0 = UNIT_W'(lead_reg);
                    job.bad0  = 1'b1;
                end
                pend_next  = '0;
                point_next = '0;
                lead_next  = '0;
            end else if (pend_reg != '0 && is_cont) begin
                pend_next  = pend_reg - PEND_W'(1);
                point_next = grown;
                if (pend_reg == PEND_W'(1)) begin
                    job_valid  = 1'b1;
                    point_next = '0;
                    lead_next  = '0;
                    if (grown < SUPP_BASE) begin
                        job.unit0 = grown[UNIT_W-1:0];
                    end else begin
                        job.two   = 1'b1;
                        job.unit0 = hi_unit;
                        job.unit1 = lo_unit;
                    end
                end
            end else if (pend_reg != '0) begin
                // broken sequence: lead byte out flagged, then the byte as fresh
                job_valid  = 1'b1;
                job.unit0  = UNIT_W'(lead_reg);
                job.bad0   = 1'b1;
                job.two    = f_emit;
                job.unit1  = UNIT_W'(in_byte);
                job.bad1   = f_bad;
                pend_next  = f_pend;
                point_next = f_emit ? '0 : f_point;
                lead_next  = f_emit ? '0 : in_byte;
            end else begin
                job_valid = f_emit;
                job.unit0 = UNIT_W'(in_byte);
                job.bad0  = f_bad;
                if (!f_emit) begin
                    pend_next  = f_pend;
                    point_next = f_point;
                    lead_next  = in_byte;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_reg  <= '0;
            point_reg <= '0;
            lead_reg  <= '0;
        end else begin
            pend_reg  <= pend_next;
            point_reg <= point_next;
            lead_reg  <= lead_next;
        end
    end

endmodule

FILE: rtl/u8u16_fifo.sv
// Short job queue between the front decoder and the back emitter.
// Depends on u8u16_pkg for the job type.
`timescale 1ns / 1ps

module u8u16_fifo
    import u8u16_pkg::*;
#(
    parameter int DEPTH = 4
) (
    input  logic aclk,
    input  logic aresetn,
    input  logic push,
    input  job_t push_job,
    output logic full,
    input  logic pop,
    output logic empty,
    output job_t head
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);

    job_t             slots [DEPTH];
    logic [PTR_W-1:0] wr_reg, wr_next;
    logic [PTR_W-1:0] rd_reg, rd_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;

    assign full  = (cnt_reg == CNT_W'(DEPTH));
    assign empty = (cnt_reg == '0);
    assign head  = slots[rd_reg];

    always_comb begin
        wr_next  = wr_reg;
        rd_next  = rd_reg;
        cnt_next = cnt_reg;
        if (push) begin
            wr_next = (wr_reg == LAST_PTR) ? '0 : wr_reg + PTR_W'(1);
        end
        if (pop) begin
            rd_next = (rd_reg == LAST_PTR) ? '0 : rd_reg + PTR_W'(1);
        end
        if (push && !pop) begin
            cnt_next = cnt_reg + CNT_W'(1);
        end else if (pop && !push) begin
            cnt_next = cnt_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slots[wr_reg] <= push_job;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end else begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

endmodule

FILE: rtl/u8u16_back.sv
// Back end: takes jobs from the queue and sends their code units out one word
// at a time through an output register. Depends on u8u16_pkg.
`timescale 1ns / 1ps

module u8u16_back
    import u8u16_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              empty,
    input  job_t              head,
    output logic              pop,
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [UNIT_W-1:0] m_tdata,
    output logic              m_tuser,
    output logic              m_tlast
);

    logic              valid_reg, valid_next;
    logic              sel_reg, sel_next;
    logic [UNIT_W-1:0] data_reg, data_next;
    logic              bad_reg, bad_next;
    logic              last_reg, last_next;
    logic              load;
    logic              final_unit;

    assign load       = !empty && (!valid_reg || m_tready);
    assign final_unit = sel_reg || !head.two;
    assign pop        = load && final_unit;

    always_comb begin
        valid_next = valid_reg;
        sel_next   = sel_reg;
        data_next  = data_reg;
        bad_next   = bad_reg;
        last_next  = last_reg;
        if (load) begin
            valid_next = 1'b1;
            data_next  = sel_reg ? head.unit1 : head.unit0;
            bad_next   = sel_reg ? head.bad1 : head.bad0;
            last_next  = final_unit;
            sel_next   = !final_unit;
        end else if (m_tready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            sel_reg   <= 1'b0;
        end else begin
            valid_reg <= valid_next;
            sel_reg   <= sel_next;
        end
    end

    always_ff @(posedge aclk) begin
        data_reg <= data_next;
        bad_reg  <= bad_next;
        last_reg <= last_next;
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = data_reg;
    assign m_tuser  = bad_reg;
    assign m_tlast  = last_reg;

endmodule
